### rtl/core/dpht_pkg.sv
// Shared types, constants and helper functions for the depth-preferred hash table.
package dpht_pkg;

   // Table geometry. The slot is the low bits of the hash, so the entry count
   // must be a power of two.
   localparam int TABLE_ENTRIES = 65536;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_WIDTH   = 16;
   localparam int HASH_WIDTH    = 64;
   localparam int INDEX_WIDTH   = 11;
   localparam int DEPTH_WIDTH   = 3;
   localparam int KIND_WIDTH    = 2;

   // Request function codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_PROBE  = 1'b1;

   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [ENTRY_WIDTH-1:0] entry_type;
   typedef logic [HASH_WIDTH-1:0]  hash_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [DEPTH_WIDTH-1:0] depth_type;
   typedef logic [KIND_WIDTH-1:0]  kind_type;

   // Status of the clearing sweep that runs after reset.
   typedef struct packed {
      logic     active;
      slot_type addr;
   } clear_status_type;

   // Packs index, depth and type into one table word.
   function automatic entry_type pack_entry(index_type idx, depth_type depth, kind_type kind);
      pack_entry = {idx, depth, kind};
   endfunction

   // Extracts the stored depth of a table word.
   function automatic depth_type entry_depth(entry_type word);
      entry_depth = word[DEPTH_WIDTH+KIND_WIDTH-1:KIND_WIDTH];
   endfunction

   // Extracts the stored move-set index of a table word.
   function automatic index_type entry_index(entry_type word);
      entry_index = word[ENTRY_WIDTH-1:ENTRY_WIDTH-INDEX_WIDTH];
   endfunction

endpackage

### rtl/core/dpht_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module dpht_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dpht_clear.sv
// Clearing sweep that zeroes every table slot after reset, one slot per cycle.
module dpht_clear (
   input  logic                        clock,
   input  logic                        reset,
   output dpht_pkg::clear_status_type  status
);
   import dpht_pkg::*;

   logic     active_ff;
   logic     active_in;
   slot_type addr_ff;
   slot_type addr_in;

   // Walk the address from zero to the last slot, then stop.
   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (active_ff) begin
         addr_in = addr_ff + slot_type'(1);
         if (addr_ff == slot_type'(TABLE_ENTRIES - 1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   assign status.active = active_ff;
   assign status.addr   = addr_ff;

endmodule

### rtl/core/depth_preferred_hash_table_top.sv
// Top level of the depth-preferred hash table: request handling and table update.
//
// Usage:
//   A request transaction is taken at a rising edge with start high and busy
//   low. req_func selects insert or probe; the slot is the low address bits of
//   req_position_hash. The table word sits in one synchronous RAM: the slot is
//   read at the accepting edge, the word is checked in the following cycle and
//   written back at the edge that ends it, so busy is high for that one cycle.
//   Each request gives exactly one response transaction: rsp_valid is high for
//   one cycle, registered through pending_ff and then rsp_valid_ff, with rsp_hit,
//   rsp_found_set_index and rsp_stored. A new request may be accepted in the
//   cycle the previous response is shown, so requests do not overlap: the
//   single RAM entry is read and written back before the next request is taken.
//   After reset, a clearing sweep writes zero to every slot, one per cycle;
//   busy stays high during the sweep. The receiver cannot stall: a response
//   is gone after its strobe cycle.
module depth_preferred_hash_table_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_func,
   input  dpht_pkg::hash_type   req_position_hash,
   input  dpht_pkg::index_type  req_move_set_index,
   input  dpht_pkg::depth_type  req_search_depth,
   input  dpht_pkg::kind_type   req_entry_kind,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output dpht_pkg::index_type  rsp_found_set_index,
   output logic                 rsp_stored
);
   import dpht_pkg::*;

   clear_status_type clr;

   logic      accept;
   slot_type  req_slot;

   logic      pending_ff;
   logic      op_func_ff;
   slot_type  op_slot_ff;
   index_type op_index_ff;
   depth_type op_depth_ff;
   kind_type  op_kind_ff;

   entry_type cur_word;
   logic      cur_valid;
   logic      probe_hit;
   logic      insert_ok;

   logic      ram_wr_en;
   slot_type  ram_wr_addr;
   entry_type ram_wr_data;

   logic      rsp_valid_ff;
   logic      rsp_hit_ff;
   logic      rsp_hit_in;
   index_type rsp_found_ff;
   index_type rsp_found_in;
   logic      rsp_stored_ff;
   logic      rsp_stored_in;

   // Clearing sweep after reset.
   dpht_clear u_clear (
      .clock  (clock),
      .reset  (reset),
      .status (clr)
   );

   // Request acceptance; the slot is the low bits of the hash.
   assign busy     = clr.active | pending_ff;
   assign accept   = start & ~busy;
   assign req_slot = req_position_hash[SLOT_BITS-1:0];

   // Table storage: read at acceptance, written back at the edge after it.
   dpht_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (cur_word)
   );

   // Request capture and pending flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_func_ff  <= req_func;
         op_slot_ff  <= req_slot;
         op_index_ff <= req_move_set_index;
         op_depth_ff <= req_search_depth;
         op_kind_ff  <= req_entry_kind;
      end
   end

   // Depth comparison against the stored word.
   assign cur_valid = (cur_word != '0);
   assign probe_hit = cur_valid && (entry_depth(cur_word) >= op_depth_ff);
   assign insert_ok = !(cur_valid && (entry_depth(cur_word) > op_depth_ff));

   // Response values for the pending transaction.
   always_comb begin
      rsp_hit_in    = 1'b0;
      rsp_found_in  = '0;
      rsp_stored_in = 1'b0;
      if (op_func_ff == FUNC_PROBE) begin
         rsp_hit_in = probe_hit;
         if (probe_hit) begin
            rsp_found_in = entry_index(cur_word);
         end
      end else begin
         rsp_stored_in = insert_ok;
      end
   end

   // Write port: the clearing sweep owns it until done, then inserts use it.
   always_comb begin
      if (clr.active) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr.addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = pending_ff && (op_func_ff == FUNC_INSERT) && insert_ok;
         ram_wr_addr = op_slot_ff;
         ram_wr_data = pack_entry(op_index_ff, op_depth_ff, op_kind_ff);
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_stored_ff <= rsp_stored_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_found_set_index = rsp_found_ff;
   assign rsp_stored          = rsp_stored_ff;

   // A response never reports both a probe hit and an insert write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_stored))
      else $error("response reports both hit and stored");

   // A miss never carries a move-set index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_found_set_index == '0))
      else $error("miss response carries a nonzero index");

   // Every accepted request yields a response.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted request produced no response");

   // No insert write may occur while the clearing sweep owns the RAM.
   assert property (@(posedge clock) disable iff (reset)
      clr.active |-> !pending_ff)
      else $error("request pending during clearing sweep");

endmodule

### tb/sv/dpht_response_checker.sv
// Checker for the depth-preferred hash table: predicts every response and compares it.
`timescale 1ns / 1ps

module dpht_response_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_func,
   input  dpht_pkg::hash_type  req_position_hash,
   input  dpht_pkg::index_type req_move_set_index,
   input  dpht_pkg::depth_type req_search_depth,
   input  dpht_pkg::kind_type  req_entry_kind,
   input  logic                rsp_valid,
   input  logic                rsp_hit,
   input  dpht_pkg::index_type rsp_found_set_index,
   input  logic                rsp_stored,
   output int                  error_total,
   output int                  awaited
);

   import dpht_pkg::*;

   typedef struct packed {
      logic      hit;
      index_type found_set_index;
      logic      stored;
   } response_type;

   // Shadow copy of the table and the responses still owed by the block.
   entry_type    slot_words [TABLE_ENTRIES];
   response_type pending_responses [$];
   int           mismatches = 0;
   int           outstanding = 0;

   assign error_total = mismatches;
   assign awaited     = outstanding;

   // Applies one request to the shadow table and returns the response it causes.
   function automatic response_type apply_request(logic func, hash_type hash, index_type idx,
                                                  depth_type depth, kind_type kind);
      slot_type     slot;
      entry_type    current;
      depth_type    held_depth;
      response_type outcome;
      slot       = hash[SLOT_BITS-1:0];
      current    = slot_words[slot];
      held_depth = current[4:2];
      outcome    = '0;
      if (func == FUNC_INSERT) begin
         // A deeper entry already in the slot is kept.
         if (current == '0 || held_depth <= depth) begin
            slot_words[slot] = {idx, depth, kind};
            outcome.stored   = 1'b1;
         end
      end else if (current != '0 && held_depth >= depth) begin
         outcome.hit             = 1'b1;
         outcome.found_set_index = current[15:5];
      end
      return outcome;
   endfunction

   // Compare each response with the oldest prediction, then record new requests.
   always @(posedge clock) begin : watch_channels
      response_type oldest;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) slot_words[i] = '0;
         pending_responses.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_responses.size() == 0) begin
               $error("response with no request outstanding: hit=%0b index=%0d stored=%0b",
                      rsp_hit, rsp_found_set_index, rsp_stored);
               mismatches = mismatches + 1;
            end else begin
               oldest = pending_responses.pop_front();
               if (rsp_hit !== oldest.hit) begin
                  $error("hit: expected %0b, actual %0b", oldest.hit, rsp_hit);
                  mismatches = mismatches + 1;
               end
               if (rsp_found_set_index !== oldest.found_set_index) begin
                  $error("found_set_index: expected %0d, actual %0d",
                         oldest.found_set_index, rsp_found_set_index);
                  mismatches = mismatches + 1;
               end
               if (rsp_stored !== oldest.stored) begin
                  $error("stored: expected %0b, actual %0b", oldest.stored, rsp_stored);
                  mismatches = mismatches + 1;
               end
            end
         end
         if (start && !busy) begin
            pending_responses.push_back(apply_request(req_func, req_position_hash,
                                                      req_move_set_index, req_search_depth,
                                                      req_entry_kind));
         end
      end
      outstanding = pending_responses.size();
   end

endmodule

### tb/sv/depth_preferred_hash_table_top_test.sv
// Top of the hash table testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module depth_preferred_hash_table_top_test;

   import dpht_pkg::*;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_func = FUNC_INSERT;
   hash_type  req_position_hash = '0;
   index_type req_move_set_index = '0;
   depth_type req_search_depth = '0;
   kind_type  req_entry_kind = '0;
   logic      rsp_valid;
   logic      rsp_hit;
   index_type rsp_found_set_index;
   logic      rsp_stored;
   int        error_total;
   int        awaited;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   depth_preferred_hash_table_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_position_hash   (req_position_hash),
      .req_move_set_index  (req_move_set_index),
      .req_search_depth    (req_search_depth),
      .req_entry_kind      (req_entry_kind),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_found_set_index (rsp_found_set_index),
      .rsp_stored          (rsp_stored)
   );

   dpht_response_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_position_hash   (req_position_hash),
      .req_move_set_index  (req_move_set_index),
      .req_search_depth    (req_search_depth),
      .req_entry_kind      (req_entry_kind),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_found_set_index (rsp_found_set_index),
      .rsp_stored          (rsp_stored),
      .error_total         (error_total),
      .awaited             (awaited)
   );

   // Drives one request transaction from a falling edge and returns at the falling edge
   // after it was taken. Idle cycles come first when they are allowed.
   task automatic send_request(input logic func, input hash_type hash, input index_type idx,
                               input depth_type depth, input kind_type kind,
                               input bit allow_idle);
      if (allow_idle) begin
         while ($urandom_range(99) < 26) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start              <= 1'b1;
      req_func           <= func;
      req_position_hash  <= hash;
      req_move_set_index <= idx;
      req_search_depth   <= depth;
      req_entry_kind     <= kind;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Safety net against a hung block; covers the clearing sweep many times over.
   initial begin
      #2_000_000;
      $display("depth_preferred_hash_table_top_test: errors");
      $finish;
   end

   initial begin : stimulus
      slot_type  hot_slots [12];
      logic      func;
      hash_type  hash;
      index_type idx;
      depth_type depth;
      kind_type  kind;
      int        wait_cycles;
      int        leftover;
      leftover = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty slots, the zero word, extremes, aliasing and depth rules.
      send_request(FUNC_PROBE,  64'h0, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'h0, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 11'd2047, 3'd7, 2'd3, 1'b1);
      send_request(FUNC_PROBE,  64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 3'd7, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'h0123_4567_89AB_FFFF, 11'd5, 3'd6, 2'd1, 1'b1);
      send_request(FUNC_INSERT, 64'h7654_3210_FEDC_FFFF, 11'd1000, 3'd7, 2'd2, 1'b1);
      send_request(FUNC_PROBE,  64'hAAAA_5555_AAAA_FFFF, 11'd2047, 3'd7, 2'd3, 1'b1);
      send_request(FUNC_INSERT, 64'h8000_0000_0000_1234, 11'd100, 3'd3, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0000_0000_0000_1234, 11'd0, 3'd3, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0000_0000_0000_1234, 11'd0, 3'd4, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'h1000_0000_0000_1234, 11'd200, 3'd2, 2'd1, 1'b1);
      send_request(FUNC_INSERT, 64'h2000_0000_0000_1234, 11'd300, 3'd4, 2'd2, 1'b1);
      send_request(FUNC_INSERT, 64'h3000_0000_0000_1234, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h4000_0000_0000_1234, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'h0000_0000_0000_0042, 11'd0, 3'd1, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0000_0000_0000_0042, 11'd0, 3'd1, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0000_0000_0000_0042, 11'd0, 3'd2, 2'd0, 1'b1);
      send_request(FUNC_INSERT, 64'h5555_AAAA_5555_0000, 11'd7, 3'd0, 2'd1, 1'b1);
      send_request(FUNC_PROBE,  64'hFFFF_FFFF_FFFF_0000, 11'd0, 3'd0, 2'd0, 1'b1);
      send_request(FUNC_PROBE,  64'h0000_0000_0000_7777, 11'd2047, 3'd7, 2'd3, 1'b1);

      // A few hot slots keep inserts and probes colliding; the rest spread everywhere.
      hot_slots[0] = '0;
      hot_slots[1] = '1;
      for (int i = 2; i < 12; i++) hot_slots[i] = slot_type'($urandom_range(65535));

      for (int n = 0; n < 1650; n++) begin
         // Now and then let the block drain completely before going on.
         if (n % 400 == 200) begin
            start <= 1'b0;
            @(negedge clock);
            while (awaited != 0) @(negedge clock);
         end
         func = 1'($urandom_range(1));
         hash = {$urandom, $urandom};
         if ($urandom_range(99) < 80) hash[SLOT_BITS-1:0] = hot_slots[$urandom_range(11)];
         idx   = index_type'($urandom_range(2047));
         depth = depth_type'($urandom_range(7));
         kind  = ($urandom_range(99) < 10) ? 2'd0 : 2'($urandom_range(3, 1));
         // Occasionally an insert whose packed word is zero.
         if (func == FUNC_INSERT && $urandom_range(99) < 4) begin
            idx   = '0;
            depth = '0;
            kind  = '0;
         end
         send_request(func, hash, idx, depth, kind, !(n >= 600 && n < 900));
      end
      start <= 1'b0;

      // Let every outstanding response arrive, then allow a short tail.
      for (wait_cycles = 0; wait_cycles < 1000 && awaited != 0; wait_cycles++) begin
         @(negedge clock);
      end
      if (awaited != 0) begin
         $error("%0d responses never arrived", awaited);
         leftover = awaited;
      end
      repeat (8) @(posedge clock);

      if (error_total == 0 && leftover == 0) begin
         $display("depth_preferred_hash_table_top_test: clean");
      end else begin
         $display("depth_preferred_hash_table_top_test: errors");
      end
      $finish;
   end

endmodule

### depth_preferred_hash_table_top.f
rtl/core/dpht_pkg.sv
rtl/core/dpht_ram.sv
rtl/core/dpht_clear.sv
rtl/core/depth_preferred_hash_table_top.sv
tb/sv/dpht_response_checker.sv
tb/sv/depth_preferred_hash_table_top_test.sv
